// ===== rtl/sml_pkg.sv =====
// Package for the sticky modifier latch: key codes, mask bits and field widths.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package sml_pkg;

    localparam int KEY_CODE_W  = 8;
    localparam int TIME_W      = 32;
    localparam int MOD_MASK_W  = 7;
    localparam int LATCH_W     = 4;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [KEY_CODE_W-1:0] CODE_LSHIFT = 8'd42;
    localparam logic [KEY_CODE_W-1:0] CODE_RSHIFT = 8'd54;
    localparam logic [KEY_CODE_W-1:0] CODE_CTRL   = 8'd29;
    localparam logic [KEY_CODE_W-1:0] CODE_ALT    = 8'd56;
    localparam logic [KEY_CODE_W-1:0] CODE_LSUPER = 8'd125;
    localparam logic [KEY_CODE_W-1:0] CODE_RSUPER = 8'd126;

    localparam logic [MOD_MASK_W-1:0] BIT_NONE  = 7'h00;
    localparam logic [MOD_MASK_W-1:0] BIT_SHIFT = 7'h01;
    localparam logic [MOD_MASK_W-1:0] BIT_CTRL  = 7'h04;
    localparam logic [MOD_MASK_W-1:0] BIT_ALT   = 7'h08;
    localparam logic [MOD_MASK_W-1:0] BIT_SUPER = 7'h40;

    localparam logic [LATCH_W-1:0] SLOT_NONE   = 4'b0000;
    localparam logic [LATCH_W-1:0] SLOT_CTRL   = 4'b0001;
    localparam logic [LATCH_W-1:0] SLOT_ALT    = 4'b0010;
    localparam logic [LATCH_W-1:0] SLOT_LSUPER = 4'b0100;
    localparam logic [LATCH_W-1:0] SLOT_RSUPER = 4'b1000;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd500000;

    // Register index of the double-tap window, taken from paddr above the byte offset.
    localparam logic REG_WINDOW = 1'b0;

endpackage : sml_pkg

`default_nettype wire

// ===== rtl/sml_if.sv =====
// Valid/ready channel interfaces for key event items and result items.
// Depends on sml_pkg for field widths.
`default_nettype none

interface sml_key_if
    import sml_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [KEY_CODE_W-1:0] key_code;
    logic                  pressed;
    logic [TIME_W-1:0]     time_us;

    modport source (output valid, key_code, pressed, time_us, input ready);
    modport sink (input valid, key_code, pressed, time_us, output ready);
endinterface : sml_key_if

interface sml_result_if
    import sml_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [MOD_MASK_W-1:0] modifiers;
    logic                  modifiers_valid;
    logic                  event_valid;
    logic [KEY_CODE_W-1:0] event_code;
    logic                  event_down;
    logic                  shift_lit;

    modport source (output valid, modifiers, modifiers_valid, event_valid, event_code,
                    event_down, shift_lit, input ready);
    modport sink (input valid, modifiers, modifiers_valid, event_valid, event_code,
                  event_down, shift_lit, output ready);
endinterface : sml_result_if

`default_nettype wire

// ===== rtl/sticky_modifier_latch_unit.sv =====
// Top level of the sticky modifier latch: state update, result register, APB register.
// Depends on sml_pkg and the channel interfaces in sml_if.sv.
`default_nettype none

// Each accepted key item produces exactly one result item in the next cycle. The
// sticky state is updated at the edge where the item is accepted, and the result
// waits in a single output register; a new item is taken in every cycle in which
// that register is empty or is being drained, so unless stalled the unit sustains one
// item per cycle. The double-tap window sits in one APB register at byte address 0.
module sticky_modifier_latch_unit
    import sml_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sml_key_if.sink                    key_in,
    sml_result_if.source               result_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [TIME_W-1:0]     window_reg;
    logic                  one_shot_reg, one_shot_next;
    logic                  locked_reg, locked_next;
    logic [TIME_W-1:0]     stamp_reg, stamp_next;
    logic [LATCH_W-1:0]    latched_reg, latched_next;
    logic [MOD_MASK_W-1:0] mask_reg, mask_next;

    logic                  out_valid_reg;
    logic [MOD_MASK_W-1:0] modifiers_reg;
    logic                  mods_valid_reg, mods_valid_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [KEY_CODE_W-1:0] ev_code_reg, ev_code_next;
    logic                  ev_down_reg, ev_down_next;
    logic                  lit_reg;

    logic                  accept;
    logic                  shift_key;
    logic [LATCH_W-1:0]    slot;
    logic [MOD_MASK_W-1:0] slot_bit;
    logic [TIME_W-1:0]     gap;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_WINDOW) ? window_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite && paddr[APB_ADDR_W-1] == REG_WINDOW)
        begin
            window_reg <= pwdata;
        end
    end

    assign key_in.ready = !out_valid_reg || result_out.ready;
    assign accept       = key_in.valid && key_in.ready;

    assign shift_key = (key_in.key_code == CODE_LSHIFT) || (key_in.key_code == CODE_RSHIFT);
    assign gap       = key_in.time_us - stamp_reg;

    always_comb
    begin
        case (key_in.key_code)
            CODE_CTRL:
            begin
                slot     = SLOT_CTRL;
                slot_bit = BIT_CTRL;
            end
            CODE_ALT:
            begin
                slot     = SLOT_ALT;
                slot_bit = BIT_ALT;
            end
            CODE_LSUPER:
            begin
                slot     = SLOT_LSUPER;
                slot_bit = BIT_SUPER;
            end
            CODE_RSUPER:
            begin
                slot     = SLOT_RSUPER;
                slot_bit = BIT_SUPER;
            end
            default:
            begin
                slot     = SLOT_NONE;
                slot_bit = BIT_NONE;
            end
        endcase
    end

    always_comb
    begin
        one_shot_next   = one_shot_reg;
        locked_next     = locked_reg;
        stamp_next      = stamp_reg;
        latched_next    = latched_reg;
        mask_next       = mask_reg;
        mods_valid_next = 1'b0;
        ev_valid_next   = 1'b0;
        ev_code_next    = '0;
        ev_down_next    = 1'b0;

        if (shift_key)
        begin
            mods_valid_next = 1'b1;
            if (key_in.pressed)
            begin
                stamp_next = key_in.time_us;
                if (locked_reg)
                begin
                    locked_next   = 1'b0;
                    one_shot_next = 1'b0;
                    mask_next     = mask_reg & ~BIT_SHIFT;
                end
                else if (one_shot_reg && gap < window_reg)
                begin
                    one_shot_next = 1'b0;
                    locked_next   = 1'b1;
                end
                else if (one_shot_reg)
                begin
                    one_shot_next = 1'b0;
                    mask_next     = mask_reg & ~BIT_SHIFT;
                end
                else
                begin
                    one_shot_next = 1'b1;
                    mask_next     = mask_reg | BIT_SHIFT;
                end
            end
        end
        else if (slot != SLOT_NONE)
        begin
            if (key_in.pressed)
            begin
                latched_next    = latched_reg ^ slot;
                mods_valid_next = 1'b1;
                ev_valid_next   = 1'b1;
                ev_code_next    = key_in.key_code;
                if ((latched_next & slot) != SLOT_NONE)
                begin
                    mask_next    = mask_reg | slot_bit;
                    ev_down_next = 1'b1;
                end
                else
                begin
                    mask_next = mask_reg & ~slot_bit;
                end
            end
        end
        else
        begin
            ev_valid_next = 1'b1;
            ev_code_next  = key_in.key_code;
            ev_down_next  = key_in.pressed;
            if (one_shot_reg && !locked_reg)
            begin
                one_shot_next   = 1'b0;
                mask_next       = mask_reg & ~BIT_SHIFT;
                mods_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_shot_reg  <= 1'b0;
            locked_reg    <= 1'b0;
            stamp_reg     <= '0;
            latched_reg   <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                one_shot_reg <= one_shot_next;
                locked_reg   <= locked_next;
                stamp_reg    <= stamp_next;
                latched_reg  <= latched_next;
                mask_reg     <= mask_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            modifiers_reg  <= mask_next;
            mods_valid_reg <= mods_valid_next;
            ev_valid_reg   <= ev_valid_next;
            ev_code_reg    <= ev_code_next;
            ev_down_reg    <= ev_down_next;
            lit_reg        <= one_shot_next || locked_next;
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.modifiers       = modifiers_reg;
    assign result_out.modifiers_valid = mods_valid_reg;
    assign result_out.event_valid     = ev_valid_reg;
    assign result_out.event_code      = ev_code_reg;
    assign result_out.event_down      = ev_down_reg;
    assign result_out.shift_lit       = lit_reg;

endmodule : sticky_modifier_latch_unit

`default_nettype wire
